// ===== rtl/multichannel_pwm_event_scheduler_macros.svh =====
// Assertion macros for the multichannel PWM event scheduler.
// Used by the top level; depends on nothing.
`ifndef MULTICHANNEL_PWM_EVENT_SCHEDULER_MACROS_SVH
`define MULTICHANNEL_PWM_EVENT_SCHEDULER_MACROS_SVH

// same-cycle implication
`define MPES_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mpes_pkg.sv =====
// Shared types and constants of the multichannel PWM event scheduler.
// Used by mpes_ctrl, mpes_dp and the top level; depends on nothing.
package mpes_pkg;

    localparam int CHANNELS_DEF = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL_US = 2'd1;

    localparam logic [7:0] TICKS_PER_US_RST    = 8'd25;
    localparam logic [9:0] MIN_INTERVAL_US_RST = 10'd20;

    localparam logic [31:0] FIRST_NEXT = 32'h7fff_ffff;

    typedef enum logic [1:0] {
        OP_TIMER,
        OP_ENABLE,
        OP_DISABLE,
        OP_ADJUST
    } t_op;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_NOFREE,
        RES_TIMER,
        RES_ENABLE
    } t_res_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_WR_ON,
        ST_WR_OFF,
        ST_SWEEP,
        ST_WALK,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  channel;
        logic [23:0] on_time_us;
        logic [23:0] off_time_us;
        logic [31:0] now;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  assigned_channel;
        logic        no_free_slot;
        logic [7:0]  pin_levels;
        logic [31:0] next_delay;
        logic        delay_valid;
        logic        timer_running;
    } t_out_item;

    typedef struct packed {
        logic      load;
        logic      prep;
        logic      wr_on;
        logic      wr_off;
        logic      dis_ch;
        logic      cnt_clr;
        logic      walk_en;
        logic      sweep_en;
        logic      res_load;
        t_res_kind kind;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic ch_ok;
        logic no_free;
        logic any_en;
        logic walk_done;
        logic sweep_last;
        logic out_full;
    } t_dp_stat;

endpackage

// ===== rtl/mpes_ctrl.sv =====
// Controller state machine of the PWM event scheduler.
// Drives mpes_dp through t_dp_cmd; depends on mpes_pkg.
module mpes_ctrl
    import mpes_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state    r_state, n_state;
    t_res_kind r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kind  <= RES_NONE;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_PREP;
            end
            ST_PREP: begin
                case (i_stat.op)
                    OP_TIMER: begin
                        if (i_stat.any_en) begin
                            n_kind  = RES_TIMER;
                            n_state = ST_WALK;
                        end else begin
                            n_kind  = RES_NONE;
                            n_state = ST_RESULT;
                        end
                    end
                    OP_ENABLE: begin
                        if (i_stat.no_free) begin
                            n_kind  = RES_NOFREE;
                            n_state = ST_RESULT;
                        end else begin
                            n_kind  = RES_ENABLE;
                            n_state = ST_WR_ON;
                        end
                    end
                    OP_ADJUST: begin
                        n_kind  = RES_NONE;
                        n_state = i_stat.ch_ok ? ST_WR_ON : ST_RESULT;
                    end
                    default: begin
                        n_kind  = RES_NONE;
                        n_state = ST_RESULT;
                    end
                endcase
            end
            ST_WR_ON: begin
                n_state = ST_WR_OFF;
            end
            ST_WR_OFF: begin
                n_state = (r_kind == RES_ENABLE) ? ST_SWEEP : ST_RESULT;
            end
            ST_SWEEP: begin
                if (i_stat.sweep_last) n_state = ST_RESULT;
            end
            ST_WALK: begin
                if (i_stat.walk_done) n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (!i_stat.out_full) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.kind = r_kind;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_PREP: begin
                case (i_stat.op)
                    OP_TIMER:   o_cmd.cnt_clr = i_stat.any_en;
                    OP_ENABLE:  o_cmd.prep    = !i_stat.no_free;
                    OP_ADJUST:  o_cmd.prep    = i_stat.ch_ok;
                    OP_DISABLE: o_cmd.dis_ch  = 1'b1;
                    default:    o_cmd.dis_ch  = 1'b0;
                endcase
            end
            ST_WR_ON: begin
                o_cmd.wr_on = 1'b1;
            end
            ST_WR_OFF: begin
                o_cmd.wr_off  = 1'b1;
                o_cmd.cnt_clr = (r_kind == RES_ENABLE);
            end
            ST_SWEEP: begin
                o_cmd.sweep_en = 1'b1;
            end
            ST_WALK: begin
                o_cmd.walk_en = 1'b1;
            end
            ST_RESULT: begin
                o_cmd.res_load = !i_stat.out_full;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/mpes_dp.sv =====
// Datapath of the PWM event scheduler: config registers, channel flags,
// event time and phase length memories, channel walk pipeline, result register.
// Depends on mpes_pkg; commanded by mpes_ctrl.
module mpes_dp
    import mpes_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out
);

    localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNTW = $clog2(CHANNELS + 1);
    localparam int PLD  = CHANNELS * 4;
    localparam int PW   = (CHANNELS > 8) ? CHANNELS : 8;
    localparam logic [CNTW-1:0] CNT_END  = CNTW'(CHANNELS);
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(CHANNELS - 1);

    // configuration
    logic [7:0]  r_tpu;
    logic [9:0]  r_mint;
    logic [17:0] r_min_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu  <= TICKS_PER_US_RST;
            r_mint <= MIN_INTERVAL_US_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TICKS_PER_US:    r_tpu  <= i_cfg_data[7:0];
                CFG_MIN_INTERVAL_US: r_mint <= i_cfg_data;
                default:             r_tpu  <= r_tpu;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_min_ticks <= {10'b0, r_tpu} * {8'b0, r_mint};
    end

    // latched input beat
    t_in_item r_in;
    t_op      op;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in;
    end

    assign op = t_op'(r_in.cmd);

    // channel flags
    logic [CHANNELS-1:0] r_en, r_plo, r_ab, r_sw, r_pin;
    logic [CHANNELS-1:0] n_en, n_plo, n_ab, n_sw, n_pin;
    logic [CW-1:0]       ch_k, free_k, r_slot;
    logic                ch_ok, no_free, r_buf;

    assign ch_k    = CW'(r_in.channel);
    assign ch_ok   = ({29'b0, r_in.channel} < 32'(CHANNELS));
    assign no_free = &r_en;

    always_comb begin
        free_k = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (!r_en[i]) free_k = CW'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_slot <= (op == OP_ENABLE) ? free_k : ch_k;
            r_buf  <= (op == OP_ENABLE) ? 1'b0 : ~r_ab[ch_k];
        end
    end

    // phase length product, one multiplier shared by on and off times
    logic [23:0]   mul_a;
    logic [31:0]   prod;
    logic [CW+1:0] pl_wa;

    assign mul_a = i_cmd.wr_off ? r_in.off_time_us : r_in.on_time_us;
    assign prod  = {8'b0, mul_a} * {24'b0, r_tpu};
    assign pl_wa = {r_slot, r_buf, i_cmd.wr_off};

    // walk / sweep counter
    logic [CNTW-1:0] r_cnt;
    logic            issuing;
    logic [CW-1:0]   rd_k;
    logic            buf_t, ph_t;
    logic [CW+1:0]   pl_ra;

    assign issuing = i_cmd.walk_en && (r_cnt != CNT_END);
    assign rd_k    = issuing ? r_cnt[CW-1:0] : '0;
    assign ph_t    = ~r_plo[rd_k];
    assign buf_t   = (r_plo[rd_k] && r_sw[rd_k]) ? ~r_ab[rd_k] : r_ab[rd_k];
    assign pl_ra   = {rd_k, buf_t, ph_t};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (issuing || i_cmd.sweep_en) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // pipeline registers
    logic          r_s1_v, r_s2_v, r_s3_v, r_s2_tog;
    logic [CW-1:0] r_s1_k, r_s2_k;
    logic [31:0]   r_et_q, r_pl_q, r_s2_d, r_s2_et, r_s2_pl, r_s3_d, r_next;
    logic [31:0]   d1, dn, etn, dc;
    logic          tog1;

    // memories
    logic [31:0]   mem_et [0:CHANNELS-1];
    logic [31:0]   mem_pl [0:PLD-1];
    logic          et_we;
    logic [CW-1:0] et_wa;
    logic [31:0]   et_wd;

    assign et_we = i_cmd.sweep_en || (r_s2_v && r_s2_tog);
    assign et_wa = i_cmd.sweep_en ? r_cnt[CW-1:0] : r_s2_k;
    assign et_wd = i_cmd.sweep_en ? r_in.now : etn;

    always_ff @(posedge i_clk) begin
        if (et_we) mem_et[et_wa] <= et_wd;
        r_et_q <= mem_et[rd_k];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_on || i_cmd.wr_off) mem_pl[pl_wa] <= prod;
        r_pl_q <= mem_pl[pl_ra];
    end

    // stage 1: lateness and toggle
    assign d1   = r_et_q - r_in.now;
    assign tog1 = (d1 == 32'd0) || d1[31];

    // stage 2: add new phase length, clamp
    assign dn  = r_s2_d + r_s2_pl;
    assign etn = r_s2_et + r_s2_pl;
    assign dc  = r_s2_tog ? (dn[31] ? 32'd0 : dn) : r_s2_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_s1_v <= issuing && r_en[rd_k];
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_k   <= rd_k;
        r_s2_k   <= r_s1_k;
        r_s2_tog <= tog1;
        r_s2_d   <= d1;
        r_s2_et  <= r_et_q;
        r_s2_pl  <= r_pl_q;
        r_s3_d   <= dc;
        if (i_cmd.cnt_clr) begin
            r_next <= FIRST_NEXT;
        end else if (r_s3_v && (r_s3_d < r_next)) begin
            r_next <= r_s3_d;
        end
    end

    // flag updates
    always_comb begin
        n_en  = r_en;
        n_plo = r_plo;
        n_ab  = r_ab;
        n_sw  = r_sw;
        n_pin = r_pin;
        if (i_cmd.wr_off) begin
            if (op == OP_ENABLE) begin
                n_ab[r_slot]  = 1'b0;
                n_pin[r_slot] = 1'b1;
                n_sw[r_slot]  = 1'b0;
                n_en[r_slot]  = 1'b1;
                n_plo         = n_plo | n_en;
            end else begin
                n_sw[r_slot] = 1'b1;
            end
        end
        if (i_cmd.dis_ch && ch_ok) n_en[ch_k] = 1'b0;
        if (r_s1_v && tog1) begin
            n_plo[r_s1_k] = ~r_plo[r_s1_k];
            if (r_plo[r_s1_k]) begin
                n_pin[r_s1_k] = 1'b1;
                if (r_sw[r_s1_k]) begin
                    n_ab[r_s1_k] = ~r_ab[r_s1_k];
                    n_sw[r_s1_k] = 1'b0;
                end
            end else begin
                n_pin[r_s1_k] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en  <= '0;
            r_plo <= '0;
            r_ab  <= '0;
            r_sw  <= '0;
            r_pin <= '0;
        end else begin
            r_en  <= n_en;
            r_plo <= n_plo;
            r_ab  <= n_ab;
            r_sw  <= n_sw;
            r_pin <= n_pin;
        end
    end

    // result register
    logic [PW-1:0] pin_pad;
    logic [31:0]   ext_min, tdelay;
    logic          r_out_v;
    t_out_item     r_out;

    assign pin_pad = PW'(r_pin);
    assign ext_min = {14'b0, r_min_ticks};
    assign tdelay  = (r_next < ext_min) ? ext_min : r_next;

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out.assigned_channel <= 3'd0;
            r_out.no_free_slot     <= 1'b0;
            r_out.next_delay       <= 32'd0;
            r_out.delay_valid      <= 1'b0;
            r_out.pin_levels       <= pin_pad[7:0];
            r_out.timer_running    <= |r_en;
            case (i_cmd.kind)
                RES_NOFREE: begin
                    r_out.no_free_slot <= 1'b1;
                end
                RES_ENABLE: begin
                    r_out.assigned_channel <= 3'(r_slot);
                    r_out.next_delay       <= ext_min;
                    r_out.delay_valid      <= 1'b1;
                end
                RES_TIMER: begin
                    r_out.next_delay  <= tdelay;
                    r_out.delay_valid <= 1'b1;
                end
                default: begin
                    r_out.delay_valid <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    assign o_stat.op         = op;
    assign o_stat.ch_ok      = ch_ok;
    assign o_stat.no_free    = no_free;
    assign o_stat.any_en     = |r_en;
    assign o_stat.walk_done  = (r_cnt == CNT_END) && !r_s1_v && !r_s2_v && !r_s3_v;
    assign o_stat.sweep_last = (r_cnt == CNT_LAST);
    assign o_stat.out_full   = r_out_v;

endmodule

// ===== rtl/multichannel_pwm_event_scheduler.sv =====
// Top level of the multichannel PWM event scheduler.
// Instantiates mpes_ctrl and mpes_dp; depends on mpes_pkg and the macros header.
//
// Input channel (i_in_valid/o_in_ready, i_in) takes one command beat: timer
// event, enable, disable or adjust. Output channel (o_out_valid/i_out_ready,
// o_out) returns exactly one result beat per command.
// Config port: i_cfg_we with i_cfg_idx 0 (ticks per us) or 1 (minimum
// interval in us); other indexes are ignored. Write only while idle.
// One command at a time. Steps from input beat to result beat:
//   timer event with channels enabled: a channel walk, one channel issued per
//     cycle into a three-stage pipeline, then a drain check
//   enable: two phase length writes through one multiplier, then an event
//     time sweep over all channels
//   adjust: two phase length writes; disable and others go straight to result.
// A new beat is taken in the first idle cycle after the result state, so an
// item holds the block until its result is loaded; a result waiting in the
// output register does not block the next command, which then holds in its
// result state until the receiver takes the waiting beat.
// Reset clears all channel flags and pins, sets the config defaults and
// empties the output register; no memory clearing pass is needed.
`include "multichannel_pwm_event_scheduler_macros.svh"

module multichannel_pwm_event_scheduler
    import mpes_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    mpes_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    mpes_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    `MPES_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input taken while busy")
    `MPES_ASSERT_NOW(a_delay_zero, i_clk, i_rst_n, o_out_valid && !o_out.delay_valid, o_out.next_delay == 32'd0, "delay without valid flag")
    `MPES_ASSERT_NOW(a_delay_running, i_clk, i_rst_n, o_out_valid && o_out.delay_valid, o_out.timer_running && !o_out.no_free_slot, "delay with no channel running")

endmodule

// ===== tb/sv/multichannel_pwm_event_scheduler_test.sv =====
// Self-checking testbench for the multichannel PWM event scheduler: directed
// table then random command traffic; results checked against the model or table.
// Depends on mpes_pkg and the multichannel_pwm_event_scheduler RTL.
module multichannel_pwm_event_scheduler_test;
    import mpes_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        t_in_item  it;
        logic      typed;
        t_out_item want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out;

    // scheduler model state
    logic [7:0]  chan_on;
    logic [7:0]  chan_low;
    logic [7:0]  chan_buf;
    logic [7:0]  chan_swap;
    logic [31:0] chan_event [8];
    logic [31:0] chan_len [8][2][2];
    logic [7:0]  pin_image;
    logic [7:0]  cfg_tpu;
    logic [9:0]  cfg_miv;

    t_out_item   expected_results [$];
    t_row        directed_rows [$];
    int unsigned mismatch_count = 0;
    logic [31:0] clock_now = 32'd0;
    logic [31:0] delay_hint = 32'd500;
    bit          steady_run = 1'b0;

    multichannel_pwm_event_scheduler u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_in_item beat_in(t_op op, logic [2:0] ch, logic [23:0] on_us,
                                         logic [23:0] off_us, logic [31:0] now);
        t_in_item b;
        b.cmd         = op;
        b.channel     = ch;
        b.on_time_us  = on_us;
        b.off_time_us = off_us;
        b.now         = now;
        return b;
    endfunction

    function automatic t_out_item beat_out(logic [2:0] ch, logic nofree, logic [7:0] pins,
                                           logic [31:0] delay, logic valid, logic running);
        t_out_item b;
        b.assigned_channel = ch;
        b.no_free_slot     = nofree;
        b.pin_levels       = pins;
        b.next_delay       = delay;
        b.delay_valid      = valid;
        b.timer_running    = running;
        return b;
    endfunction

    function automatic logic [23:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 24'd0;
        if (r == 1) return 24'($urandom);
        return 24'($urandom_range(1, 300));
    endfunction

    task automatic advance_scheduler(input t_in_item it, output t_out_item res);
        logic [31:0] span;
        logic [31:0] lead;
        logic [31:0] soonest;
        logic        b;
        int          slot;
        int          i;
        span = {24'd0, cfg_tpu} * {22'd0, cfg_miv};
        res  = '0;
        case (it.cmd)
            OP_TIMER: begin
                if (chan_on != 8'd0) begin
                    soonest = FIRST_NEXT;
                    for (i = 0; i < 8; i++) begin
                        if (chan_on[i]) begin
                            lead = chan_event[i] - it.now;
                            if (lead == 32'd0 || lead[31]) begin
                                chan_low[i] = !chan_low[i];
                                if (!chan_low[i]) begin
                                    pin_image[i] = 1'b1;
                                    if (chan_swap[i]) begin
                                        chan_buf[i]  = !chan_buf[i];
                                        chan_swap[i] = 1'b0;
                                    end
                                end else begin
                                    pin_image[i] = 1'b0;
                                end
                                lead = lead + chan_len[i][chan_buf[i]][chan_low[i]];
                                chan_event[i] = it.now + lead;
                                if (lead[31]) lead = 32'd0;
                            end
                            if (lead < soonest) soonest = lead;
                        end
                    end
                    if (soonest < span) soonest = span;
                    res.next_delay  = soonest;
                    res.delay_valid = 1'b1;
                end
            end
            OP_ENABLE: begin
                slot = -1;
                for (i = 7; i >= 0; i--) begin
                    if (!chan_on[i]) slot = i;
                end
                if (slot < 0) begin
                    res.no_free_slot = 1'b1;
                end else begin
                    chan_len[slot][0][0] = {8'd0, it.on_time_us} * {24'd0, cfg_tpu};
                    chan_len[slot][0][1] = {8'd0, it.off_time_us} * {24'd0, cfg_tpu};
                    chan_buf[slot]  = 1'b0;
                    chan_swap[slot] = 1'b0;
                    pin_image[slot] = 1'b1;
                    chan_on[slot]   = 1'b1;
                    for (i = 0; i < 8; i++) begin
                        if (chan_on[i]) begin
                            chan_low[i]   = 1'b1;
                            chan_event[i] = it.now;
                        end
                    end
                    res.assigned_channel = slot[2:0];
                    res.next_delay       = span;
                    res.delay_valid      = 1'b1;
                end
            end
            OP_DISABLE: begin
                chan_on[it.channel] = 1'b0;
            end
            default: begin
                b = !chan_buf[it.channel];
                chan_len[it.channel][b][0] = {8'd0, it.on_time_us} * {24'd0, cfg_tpu};
                chan_len[it.channel][b][1] = {8'd0, it.off_time_us} * {24'd0, cfg_tpu};
                chan_swap[it.channel] = 1'b1;
            end
        endcase
        res.pin_levels    = pin_image;
        res.timer_running = |chan_on;
    endtask

    // called at a rising edge; returns at the edge that takes the beat
    task automatic send_beat(input t_in_item it, input logic typed, input t_out_item want);
        t_out_item res;
        if (!steady_run && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        advance_scheduler(it, res);
        if (res.delay_valid) delay_hint = res.next_delay;
        expected_results.push_back(typed ? want : res);
    endtask

    task automatic go_idle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [9:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_TICKS_PER_US) cfg_tpu = data[7:0];
        else if (idx == CFG_MIN_INTERVAL_US) cfg_miv = data;
    endtask

    task automatic set_config(input logic [7:0] tpu, input logic [9:0] miv);
        cfg_write(CFG_TICKS_PER_US, {2'b00, tpu});
        cfg_write(CFG_MIN_INTERVAL_US, miv);
        cfg_write(CFG_SPARE, 10'($urandom_range(0, 1023)));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic make_random_item(output t_in_item it);
        int unsigned pick;
        logic [2:0]  ch;
        int          jitter;
        pick = $urandom_range(0, 99);
        if (chan_on == 8'd0 && pick < 60) it.cmd = OP_ENABLE;
        else if (pick < 50) it.cmd = OP_TIMER;
        else if (pick < 68) it.cmd = OP_ENABLE;
        else if (pick < 82) it.cmd = OP_ADJUST;
        else it.cmd = OP_DISABLE;
        ch = 3'($urandom_range(0, 7));
        if (chan_on != 8'd0 && $urandom_range(0, 9) < 7) begin
            while (!chan_on[ch]) ch = ch + 3'd1;
        end
        it.channel     = ch;
        it.on_time_us  = pick_len();
        it.off_time_us = pick_len();
        jitter = $urandom_range(0, 220);
        jitter = jitter - 20;
        case ($urandom_range(0, 19))
            0, 1: clock_now = $urandom;
            2, 3: clock_now = clock_now + $urandom_range(0, 5000);
            default: begin
                if (it.cmd == OP_TIMER) clock_now = clock_now + delay_hint + jitter;
                else clock_now = clock_now + $urandom_range(0, 100);
            end
        endcase
        it.now = clock_now;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none actual %0h",
                         $time, o_out);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("assigned_channel", 32'(want.assigned_channel),
                            32'(o_out.assigned_channel));
                check_field("no_free_slot", 32'(want.no_free_slot), 32'(o_out.no_free_slot));
                check_field("pin_levels", 32'(want.pin_levels), 32'(o_out.pin_levels));
                check_field("next_delay", want.next_delay, o_out.next_delay);
                check_field("delay_valid", 32'(want.delay_valid), 32'(o_out.delay_valid));
                check_field("timer_running", 32'(want.timer_running),
                            32'(o_out.timer_running));
            end
        end
    end

    initial begin : out_stall
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!steady_run && $urandom_range(0, 2) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        t_in_item it;
        int       phase;
        int       k;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_TICKS_PER_US;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        chan_on    = '0;
        chan_low   = '0;
        chan_buf   = '0;
        chan_swap  = '0;
        pin_image  = '0;
        cfg_tpu    = TICKS_PER_US_RST;
        cfg_miv    = MIN_INTERVAL_US_RST;

        // idle timer, disable and adjust of free channels, first two enables
        directed_rows.push_back('{beat_in(OP_TIMER, 3'd0, 24'd0, 24'd0, 32'd0), 1'b1,
                                  beat_out(3'd0, 1'b0, 8'h00, 32'd0, 1'b0, 1'b0)});
        directed_rows.push_back('{beat_in(OP_DISABLE, 3'd7, 24'hffffff, 24'hffffff,
                                          32'hffffffff), 1'b1,
                                  beat_out(3'd0, 1'b0, 8'h00, 32'd0, 1'b0, 1'b0)});
        directed_rows.push_back('{beat_in(OP_ADJUST, 3'd5, 24'hffffff, 24'hffffff, 32'd0),
                                  1'b1, beat_out(3'd0, 1'b0, 8'h00, 32'd0, 1'b0, 1'b0)});
        directed_rows.push_back('{beat_in(OP_ENABLE, 3'd3, 24'd40, 24'd60, 32'd1000), 1'b1,
                                  beat_out(3'd0, 1'b0, 8'h01, 32'd500, 1'b1, 1'b1)});
        directed_rows.push_back('{beat_in(OP_ENABLE, 3'd0, 24'd0, 24'd0, 32'd1000), 1'b1,
                                  beat_out(3'd1, 1'b0, 8'h03, 32'd500, 1'b1, 1'b1)});
        directed_rows.push_back('{beat_in(OP_TIMER, 3'd0, 24'd0, 24'd0, 32'd1000), 1'b0, '0});
        directed_rows.push_back('{beat_in(OP_TIMER, 3'd0, 24'd0, 24'd0, 32'd1500), 1'b0, '0});
        directed_rows.push_back('{beat_in(OP_ADJUST, 3'd0, 24'd10, 24'd5, 32'd1600), 1'b0, '0});
        directed_rows.push_back('{beat_in(OP_TIMER, 3'd0, 24'd0, 24'd0, 32'd2600), 1'b0, '0});
        // late event: remainder goes negative
        directed_rows.push_back('{beat_in(OP_TIMER, 3'd0, 24'd0, 24'd0, 32'd200000), 1'b0,
                                  '0});
        directed_rows.push_back('{beat_in(OP_ENABLE, 3'd7, 24'hffffff, 24'd1, 32'hffffff00),
                                  1'b0, '0});
        directed_rows.push_back('{beat_in(OP_ENABLE, 3'd6, 24'd1, 24'hffffff, 32'hffffff10),
                                  1'b0, '0});
        directed_rows.push_back('{beat_in(OP_ENABLE, 3'd5, 24'h555555, 24'haaaaaa,
                                          32'hffffff20), 1'b0, '0});
        directed_rows.push_back('{beat_in(OP_ENABLE, 3'd4, 24'haaaaaa, 24'h555555,
                                          32'hffffff30), 1'b0, '0});
        directed_rows.push_back('{beat_in(OP_ENABLE, 3'd2, 24'd100, 24'd200, 32'hffffff40),
                                  1'b0, '0});
        directed_rows.push_back('{beat_in(OP_ENABLE, 3'd1, 24'd300, 24'd50, 32'hffffff80),
                                  1'b0, '0});
        // every channel busy
        directed_rows.push_back('{beat_in(OP_ENABLE, 3'd0, 24'd5, 24'd5, 32'hfffffff0), 1'b0,
                                  '0});
        directed_rows.push_back('{beat_in(OP_TIMER, 3'd0, 24'd0, 24'd0, 32'h00000040), 1'b0,
                                  '0});
        directed_rows.push_back('{beat_in(OP_DISABLE, 3'd1, 24'd0, 24'd0, 32'h00000100), 1'b0,
                                  '0});
        directed_rows.push_back('{beat_in(OP_TIMER, 3'd0, 24'd0, 24'd0, 32'h00004000), 1'b0,
                                  '0});
        directed_rows.push_back('{beat_in(OP_ENABLE, 3'd3, 24'd20, 24'd20, 32'h00004100), 1'b0,
                                  '0});
        directed_rows.push_back('{beat_in(OP_ADJUST, 3'd7, 24'd0, 24'd0, 32'h00004200), 1'b0,
                                  '0});
        directed_rows.push_back('{beat_in(OP_TIMER, 3'd0, 24'd0, 24'd0, 32'h80000000), 1'b0,
                                  '0});
        directed_rows.push_back('{beat_in(OP_TIMER, 3'd0, 24'd0, 24'd0, 32'h80001000), 1'b0,
                                  '0});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < directed_rows.size(); k++) begin
            send_beat(directed_rows[k].it, directed_rows[k].typed, directed_rows[k].want);
        end
        clock_now = 32'h80001000;

        for (phase = 0; phase < 4; phase++) begin
            go_idle();
            case (phase)
                0: set_config(8'd1, 10'd1);
                1: set_config(8'd255, 10'd1000);
                default: set_config(8'($urandom_range(1, 255)),
                                    10'($urandom_range(1, 1000)));
            endcase
            if (phase == 3) steady_run = 1'b1;
            repeat (112) begin
                make_random_item(it);
                send_beat(it, 1'b0, '0);
            end
        end
        go_idle();

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== multichannel_pwm_event_scheduler.f =====
+incdir+rtl
rtl/mpes_pkg.sv
rtl/mpes_ctrl.sv
rtl/mpes_dp.sv
rtl/multichannel_pwm_event_scheduler.sv
tb/sv/multichannel_pwm_event_scheduler_test.sv
